// File: sv/bco_pkg.sv
// ----------------------------------------------------------------------------
// bco_pkg - shared types and constants of the blob centroid/orientation block
// Widths, moment sequencing codes, back-end states and the CORDIC angle table.
// ----------------------------------------------------------------------------
package bco_pkg;

    localparam int COORD_BITS    = 10;
    localparam int MAX_AREA_BITS = 20;
    localparam int FRAC_BITS     = 8;

    localparam int CNT_BITS   = MAX_AREA_BITS + 1;
    localparam int SUM_BITS   = COORD_BITS + MAX_AREA_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS + MAX_AREA_BITS + 1;
    localparam int CENT_BITS  = COORD_BITS + FRAC_BITS;
    localparam int ANGLE_BITS = FRAC_BITS + 8;
    localparam int PROD_BITS  = SQ_BITS + CNT_BITS;
    localparam int MOM_BITS   = PROD_BITS + 2;
    localparam int MUL_STEPS  = SUM_BITS;
    localparam int DVD_BITS   = SUM_BITS + FRAC_BITS;

    localparam int NORM_TOP       = 40;
    localparam int CW_BITS        = NORM_TOP + 5;
    localparam int Z_BITS         = 28;
    localparam int CORDIC_STEPS   = 23;
    localparam int STEP_IDX_BITS  = $clog2(CORDIC_STEPS);
    localparam int CTR_BITS       = $clog2(DVD_BITS + CORDIC_STEPS + 1);

    localparam logic signed [Z_BITS-1:0] Z_DEG90  = Z_BITS'(90 * 65536);
    localparam logic signed [Z_BITS-1:0] Z_DEG180 = Z_BITS'(180 * 65536);
    localparam logic signed [Z_BITS-1:0] Z_RND    = Z_BITS'(1 << (16 - FRAC_BITS));
    localparam logic signed [Z_BITS-1:0] Z_LIM    = Z_BITS'(90 << FRAC_BITS);

    typedef struct packed {
        logic [CNT_BITS-1:0] cnt;
        logic [SUM_BITS-1:0] sx;
        logic [SUM_BITS-1:0] sy;
        logic [SQ_BITS-1:0]  sxx;
        logic [SQ_BITS-1:0]  syy;
        logic [SQ_BITS-1:0]  sxy;
    } bco_sums_t;

    typedef struct packed {
        logic      valid;
        bco_sums_t sums;
    } bco_push_t;

    typedef enum logic [2:0] {
        MOP_N_SXY,
        MOP_SX_SY,
        MOP_N_SYY,
        MOP_SX_SX,
        MOP_N_SXX,
        MOP_SY_SY
    } bco_mop_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_NORM,
        BK_ROT,
        BK_DONE
    } bco_state_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [Z_BITS-1:0] atan_q16(input logic [STEP_IDX_BITS-1:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return Z_BITS'(v);
    endfunction

endpackage

// File: sv/bco_if.sv
// ----------------------------------------------------------------------------
// bco_if - stream interfaces of the blob centroid/orientation block
// Pixel input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bco_pixel_if;
    import bco_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic                  last_pixel;

    modport source (output valid, pixel_col, pixel_row, last_pixel, input ready);
    modport sink   (input valid, pixel_col, pixel_row, last_pixel, output ready);
endinterface

interface bco_result_if;
    import bco_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [CENT_BITS-1:0]         centroid_col;
    logic [CENT_BITS-1:0]         centroid_row;
    logic signed [ANGLE_BITS-1:0] axis_angle;
    logic [CNT_BITS-1:0]          area_count;

    modport source (output valid, centroid_col, centroid_row, axis_angle, area_count,
                    input ready);
    modport sink   (input valid, centroid_col, centroid_row, axis_angle, area_count,
                    output ready);
endinterface

// File: sv/bco_front.sv
// ----------------------------------------------------------------------------
// bco_front - raw moment accumulator
// Take one pixel per cycle while the queue has room, sum the raw moments, hand them on at the last pixel.
// ----------------------------------------------------------------------------
module bco_front (
    input  logic                clk,
    input  logic                rst_n,
    bco_pixel_if.sink           pixels,
    input  logic                push_ready,
    output bco_pkg::bco_push_t  push
);
    import bco_pkg::*;

    bco_sums_t               acc_reg;
    bco_sums_t               acc_next;
    bco_sums_t               sum_upd;
    logic                    accept;
    logic [2*COORD_BITS-1:0] col_sq;
    logic [2*COORD_BITS-1:0] row_sq;
    logic [2*COORD_BITS-1:0] cross_prod;

    assign pixels.ready = push_ready;
    assign accept       = pixels.valid && pixels.ready;

    assign col_sq     = pixels.pixel_col * pixels.pixel_col;
    assign row_sq     = pixels.pixel_row * pixels.pixel_row;
    assign cross_prod = pixels.pixel_col * pixels.pixel_row;

    always_comb
    begin
        sum_upd = acc_reg;
        // drop pixels once the area is full
        if (!acc_reg.cnt[CNT_BITS-1])
        begin
            sum_upd.cnt = acc_reg.cnt + CNT_BITS'(1);
            sum_upd.sx  = acc_reg.sx + SUM_BITS'(pixels.pixel_col);
            sum_upd.sy  = acc_reg.sy + SUM_BITS'(pixels.pixel_row);
            sum_upd.sxx = acc_reg.sxx + SQ_BITS'(col_sq);
            sum_upd.syy = acc_reg.syy + SQ_BITS'(row_sq);
            sum_upd.sxy = acc_reg.sxy + SQ_BITS'(cross_prod);
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
        begin
            acc_next = pixels.last_pixel ? '0 : sum_upd;
        end
    end

    assign push.valid = accept && pixels.last_pixel;
    assign push.sums  = sum_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// File: sv/bco_queue.sv
// ----------------------------------------------------------------------------
// bco_queue - two-entry queue of region moment sets
// Decouple the accumulator from the back-end sequencer.
// ----------------------------------------------------------------------------
module bco_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  bco_pkg::bco_push_t  push,
    output logic                push_ready,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bco_pkg::bco_sums_t  pop_data
);
    import bco_pkg::*;

    bco_sums_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.sums;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: sv/bco_back.sv
// ----------------------------------------------------------------------------
// bco_back - centroid and orientation sequencer
// Serial moment products, restoring division, normalisation and CORDIC.
// ----------------------------------------------------------------------------
module bco_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  bco_pkg::bco_sums_t  pop_data,
    output logic                pop_ready,
    bco_result_if.source        results
);
    import bco_pkg::*;

    bco_state_t                   state_reg;
    bco_state_t                   state_next;
    logic                         out_valid_reg;
    logic                         load_out;

    bco_sums_t                    sums_reg;
    bco_mop_t                     op_reg;
    logic                         div_sel_reg;
    logic [CTR_BITS-1:0]          ctr_reg;
    logic [PROD_BITS-1:0]         mcand_reg;
    logic [SUM_BITS-1:0]          mplier_reg;
    logic [PROD_BITS-1:0]         prod_reg;
    logic signed [MOM_BITS-1:0]   mu_reg;
    logic signed [MOM_BITS-1:0]   bx_reg;
    logic [CNT_BITS-1:0]          rem_reg;
    logic [DVD_BITS-1:0]          dvd_reg;
    logic [DVD_BITS-1:0]          quo_reg;
    logic [CENT_BITS-1:0]         cx_reg;
    logic [CENT_BITS-1:0]         cy_reg;
    logic [MOM_BITS-1:0]          mor_reg;
    logic signed [CW_BITS-1:0]    x_reg;
    logic signed [CW_BITS-1:0]    y_reg;
    logic signed [Z_BITS-1:0]     z_reg;
    logic [CENT_BITS-1:0]         res_col_reg;
    logic [CENT_BITS-1:0]         res_row_reg;
    logic [ANGLE_BITS-1:0]        res_ang_reg;
    logic [CNT_BITS-1:0]          res_cnt_reg;

    logic [PROD_BITS-1:0]         mcand_sel;
    logic [SUM_BITS-1:0]          mplier_sel;
    logic [PROD_BITS-1:0]         prod_new;
    logic signed [MOM_BITS-1:0]   prod_ext;
    logic                         mul_end;
    logic [SUM_BITS-1:0]          div_sum;
    logic [CNT_BITS:0]            rem_sh;
    logic                         rem_ge;
    logic [CNT_BITS-1:0]          rem_new;
    logic [DVD_BITS-1:0]          quo_new;
    logic                         div_end;
    logic [MOM_BITS-1:0]          abs_ay;
    logic [MOM_BITS-1:0]          abs_bx;
    logic                         mom_zero;
    logic                         mor_hi;
    logic                         norm_done;
    logic signed [CW_BITS-1:0]    x_t;
    logic signed [CW_BITS-1:0]    y_t;
    logic                         special;
    logic [STEP_IDX_BITS-1:0]     step_idx;
    logic signed [CW_BITS-1:0]    dx;
    logic signed [CW_BITS-1:0]    dy;
    logic                         rot_end;
    logic signed [Z_BITS-1:0]     z_rnd;
    logic signed [Z_BITS-1:0]     z_sh;
    logic signed [Z_BITS-1:0]     z_clamp;

    // operand selection for the serial multiplier
    always_comb
    begin
        unique case (op_reg)
            MOP_N_SXY:
            begin
                mcand_sel  = PROD_BITS'(sums_reg.sxy);
                mplier_sel = SUM_BITS'(sums_reg.cnt);
            end
            MOP_SX_SY:
            begin
                mcand_sel  = PROD_BITS'(sums_reg.sx);
                mplier_sel = sums_reg.sy;
            end
            MOP_N_SYY:
            begin
                mcand_sel  = PROD_BITS'(sums_reg.syy);
                mplier_sel = SUM_BITS'(sums_reg.cnt);
            end
            MOP_SX_SX:
            begin
                mcand_sel  = PROD_BITS'(sums_reg.sx);
                mplier_sel = sums_reg.sx;
            end
            MOP_N_SXX:
            begin
                mcand_sel  = PROD_BITS'(sums_reg.sxx);
                mplier_sel = SUM_BITS'(sums_reg.cnt);
            end
            MOP_SY_SY:
            begin
                mcand_sel  = PROD_BITS'(sums_reg.sy);
                mplier_sel = sums_reg.sy;
            end
            default:
            begin
                mcand_sel  = '0;
                mplier_sel = '0;
            end
        endcase
    end

    assign prod_new = prod_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign prod_ext = $signed(MOM_BITS'(prod_new));
    assign mul_end  = (ctr_reg == CTR_BITS'(MUL_STEPS));

    // restoring division, one quotient bit a cycle
    assign div_sum = div_sel_reg ? sums_reg.sy : sums_reg.sx;
    assign rem_sh  = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign rem_ge  = (rem_sh >= {1'b0, sums_reg.cnt});
    assign rem_new = rem_ge ? CNT_BITS'(rem_sh - {1'b0, sums_reg.cnt}) : rem_sh[CNT_BITS-1:0];
    assign quo_new = {quo_reg[DVD_BITS-2:0], rem_ge};
    assign div_end = (ctr_reg == CTR_BITS'(DVD_BITS));

    // magnitude window for normalisation
    assign abs_ay    = mu_reg[MOM_BITS-1] ? $unsigned(-mu_reg) : $unsigned(mu_reg);
    assign abs_bx    = bx_reg[MOM_BITS-1] ? $unsigned(-bx_reg) : $unsigned(bx_reg);
    assign mom_zero  = (mu_reg == '0) && (bx_reg == '0);
    assign mor_hi    = |mor_reg[MOM_BITS-1:NORM_TOP+1];
    assign norm_done = (ctr_reg != '0) && !mor_hi && mor_reg[NORM_TOP];
    assign x_t       = CW_BITS'(bx_reg);
    assign y_t       = CW_BITS'(mu_reg);
    assign special   = (y_t == '0) || (x_t == '0);

    assign step_idx = ctr_reg[STEP_IDX_BITS-1:0];
    assign dx       = y_reg >>> step_idx;
    assign dy       = x_reg >>> step_idx;
    assign rot_end  = (ctr_reg == CTR_BITS'(CORDIC_STEPS - 1));

    assign z_rnd = z_reg + Z_RND;
    assign z_sh  = z_rnd >>> (17 - FRAC_BITS);

    always_comb
    begin
        priority if (z_sh > Z_LIM)
        begin
            z_clamp = Z_LIM;
        end
        else if (z_sh < -Z_LIM)
        begin
            z_clamp = -Z_LIM;
        end
        else
        begin
            z_clamp = z_sh;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                if ((ctr_reg != '0) && mul_end && (op_reg == MOP_SY_SY))
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if ((ctr_reg != '0) && div_end && div_sel_reg)
                begin
                    state_next = BK_NORM;
                end
            end
            BK_NORM:
            begin
                if ((ctr_reg == '0) && mom_zero)
                begin
                    state_next = BK_DONE;
                end
                else if (norm_done)
                begin
                    state_next = special ? BK_DONE : BK_ROT;
                end
            end
            BK_ROT:
            begin
                if (rot_end)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (load_out)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop_ready = (state_reg == BK_IDLE);
        load_out  = (state_reg == BK_DONE) && (!out_valid_reg || results.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    sums_reg    <= pop_data;
                    op_reg      <= MOP_N_SXY;
                    div_sel_reg <= 1'b0;
                    ctr_reg     <= '0;
                    mu_reg      <= '0;
                    bx_reg      <= '0;
                end
            end
            BK_MUL:
            begin
                if (ctr_reg == '0)
                begin
                    mcand_reg  <= mcand_sel;
                    mplier_reg <= mplier_sel;
                    prod_reg   <= '0;
                    ctr_reg    <= CTR_BITS'(1);
                end
                else
                begin
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    prod_reg   <= prod_new;
                    if (mul_end)
                    begin
                        ctr_reg <= '0;
                        unique case (op_reg)
                            MOP_N_SXY:            mu_reg <= mu_reg + prod_ext;
                            MOP_SX_SY:            mu_reg <= mu_reg - prod_ext;
                            MOP_N_SYY, MOP_SX_SX: bx_reg <= bx_reg + prod_ext;
                            MOP_N_SXX, MOP_SY_SY: bx_reg <= bx_reg - prod_ext;
                            default:              bx_reg <= bx_reg;
                        endcase
                        if (op_reg != MOP_SY_SY)
                        begin
                            op_reg <= bco_mop_t'(op_reg + 3'd1);
                        end
                    end
                    else
                    begin
                        ctr_reg <= ctr_reg + CTR_BITS'(1);
                    end
                end
            end
            BK_DIV:
            begin
                if (ctr_reg == '0)
                begin
                    dvd_reg <= {div_sum, {FRAC_BITS{1'b0}}} + DVD_BITS'(sums_reg.cnt >> 1);
                    rem_reg <= '0;
                    ctr_reg <= CTR_BITS'(1);
                end
                else
                begin
                    dvd_reg <= dvd_reg << 1;
                    rem_reg <= rem_new;
                    quo_reg <= quo_new;
                    if (div_end)
                    begin
                        ctr_reg <= '0;
                        if (!div_sel_reg)
                        begin
                            cx_reg      <= quo_new[CENT_BITS-1:0];
                            div_sel_reg <= 1'b1;
                        end
                        else
                        begin
                            cy_reg <= quo_new[CENT_BITS-1:0];
                            // turn mu11 into the y argument 2*mu11
                            mu_reg <= mu_reg <<< 1;
                        end
                    end
                    else
                    begin
                        ctr_reg <= ctr_reg + CTR_BITS'(1);
                    end
                end
            end
            BK_NORM:
            begin
                if (ctr_reg == '0)
                begin
                    mor_reg <= abs_ay | abs_bx;
                    z_reg   <= '0;
                    ctr_reg <= CTR_BITS'(1);
                end
                else if (mor_hi)
                begin
                    mu_reg  <= mu_reg >>> 1;
                    bx_reg  <= bx_reg >>> 1;
                    mor_reg <= mor_reg >> 1;
                end
                else if (!mor_reg[NORM_TOP])
                begin
                    mu_reg  <= mu_reg <<< 1;
                    bx_reg  <= bx_reg <<< 1;
                    mor_reg <= mor_reg << 1;
                end
                else
                begin
                    ctr_reg <= '0;
                    x_reg   <= x_t;
                    y_reg   <= y_t;
                    priority if (y_t == '0)
                    begin
                        z_reg <= (x_t < 0) ? Z_DEG180 : '0;
                    end
                    else if (x_t == '0)
                    begin
                        z_reg <= (y_t > 0) ? Z_DEG90 : -Z_DEG90;
                    end
                    else if (x_t < 0)
                    begin
                        // pre-rotate into the right half plane
                        z_reg <= (y_t >= 0) ? Z_DEG180 : -Z_DEG180;
                        x_reg <= -x_t;
                        y_reg <= -y_t;
                    end
                    else
                    begin
                        z_reg <= '0;
                    end
                end
            end
            BK_ROT:
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_q16(step_idx);
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_q16(step_idx);
                end
                ctr_reg <= ctr_reg + CTR_BITS'(1);
            end
            BK_DONE:
            begin
                if (load_out)
                begin
                    res_col_reg <= cx_reg;
                    res_row_reg <= cy_reg;
                    res_ang_reg <= z_clamp[ANGLE_BITS-1:0];
                    res_cnt_reg <= sums_reg.cnt;
                end
            end
            default:
            begin
                ctr_reg <= '0;
            end
        endcase
    end

    assign results.valid        = out_valid_reg;
    assign results.centroid_col = res_col_reg;
    assign results.centroid_row = res_row_reg;
    assign results.axis_angle   = $signed(res_ang_reg);
    assign results.area_count   = res_cnt_reg;

endmodule

// File: sv/blob_centroid_orientation.sv
// Throughput: one pixel transfer per cycle; the back end works on one region at a time
// through the bit-serial multiplier (six products), the two restoring divisions,
// the normalisation shifts and 23 CORDIC iterations; pixels stall only while both
// queue entries hold finished regions.
// Reset (rst_n low, asynchronous) clears the sums, the queue and the sequencer.
// ----------------------------------------------------------------------------
// blob_centroid_orientation - region centroid, area and principal-axis angle
// Front accumulator, two-entry queue, and sequential centroid/angle back end.
// ----------------------------------------------------------------------------
module blob_centroid_orientation (
    input  logic         clk,
    input  logic         rst_n,
    bco_pixel_if.sink    pixels,
    bco_result_if.source results
);
    import bco_pkg::*;

    // moment sets handed from the front end at each last-pixel transfer
    bco_push_t push;
    logic      push_ready;

    // queue to back-end link
    logic      pop_valid;
    logic      pop_ready;
    bco_sums_t pop_data;

    // Accumulate the raw moments; hold the input whenever the queue is full,
    // which keeps a finished region from being dropped.
    bco_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .push_ready (push_ready),
        .push       (push)
    );

    // Buffer up to two finished regions so short regions do not stall the
    // pixel stream while the back end is busy.
    bco_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Form centroid, central moments and angle; the result register lets the
    // next region start while the previous result waits for its transfer.
    bco_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready),
        .results    (results)
    );

endmodule

// File: sv/bco_checker.sv
// ----------------------------------------------------------------------------
// bco_checker - port-level assertions of the blob centroid/orientation block
// Watch the result channel for range and hold properties.
// ----------------------------------------------------------------------------
module bco_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                res_valid,
    input logic                                res_ready,
    input logic [bco_pkg::CENT_BITS-1:0]       centroid_col,
    input logic [bco_pkg::CENT_BITS-1:0]       centroid_row,
    input logic signed [bco_pkg::ANGLE_BITS-1:0] axis_angle,
    input logic [bco_pkg::CNT_BITS-1:0]        area_count
);
    import bco_pkg::*;

    localparam logic signed [ANGLE_BITS-1:0] ANG_LIM  = ANGLE_BITS'(90 << FRAC_BITS);
    localparam logic [CENT_BITS-1:0]         CENT_MAX =
        CENT_BITS'(((1 << COORD_BITS) - 1) << FRAC_BITS);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(axis_angle)
            && $stable(area_count))
        else $error("result changed while stalled");

    a_angle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (axis_angle <= ANG_LIM) && (axis_angle >= -ANG_LIM))
        else $error("axis angle beyond 90 degrees");

    a_area: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (area_count != '0))
        else $error("result with empty region");

    a_cent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (centroid_col <= CENT_MAX) && (centroid_row <= CENT_MAX))
        else $error("centroid beyond coordinate range");

endmodule

bind blob_centroid_orientation bco_checker u_bco_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .centroid_col (results.centroid_col),
    .centroid_row (results.centroid_row),
    .axis_angle   (results.axis_angle),
    .area_count   (results.area_count)
);
